### sv/ascd_pkg.sv
// Package: shared constants and arctangent table for the soft clip drive.
`timescale 1ns / 1ps
package ascd_pkg;

  localparam int GainBits   = 16;
  localparam int ShareBits  = 13;
  localparam int GainFrac   = 12;
  localparam int AlphaMin   = 6144;
  localparam int AlphaMax   = 61440;
  localparam int ShareOne   = 4096;
  localparam int CordicSteps = 30;
  localparam int AngleBits  = 32;

  typedef enum logic [1:0] {
    REG_INPUT_GAIN  = 2'd0,
    REG_OUTPUT_GAIN = 2'd1,
    REG_CLIP_ALPHA  = 2'd2,
    REG_WET_SHARE   = 2'd3
  } reg_index_t;

  // atan(2^-i), pi/2 = 2^30
  function automatic logic [AngleBits-1:0] atan_angle(input logic [4:0] i);
    logic [AngleBits-1:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10680862;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### sv/ascd_cordic_stage.sv
// Module: one registered vectoring CORDIC micro-rotation with side payload.
`timescale 1ns / 1ps
module ascd_cordic_stage #(
  parameter int XW = 50,
  parameter int PW = 40,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [33:0]   z_in,
  input  logic [PW-1:0]        pay_in,
  output logic                 out_vld,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [33:0]   z_out,
  output logic [PW-1:0]        pay_out
);
  import ascd_pkg::*;

  logic signed [XW-1:0] xs, ys, x_next, y_next;
  logic signed [33:0]   ang, z_next;

  // rotate toward the x axis; arithmetic shift is a floor shift
  always_comb begin
    xs  = x_in >>> STEP;
    ys  = y_in >>> STEP;
    ang = 34'(atan_angle(5'(STEP)));
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ang;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_out   <= x_next;
      y_out   <= y_next;
      z_out   <= z_next;
      pay_out <= pay_in;
    end
  end

endmodule

### sv/arctan_soft_clip_drive.sv
// Top level: pipelined arctangent soft clipper with gains and dry/wet blend.
//
// Usage: samples enter on in_valid/in_stall with in_sample and leave on
// out_valid/out_stall with out_sample. A transaction completes at a rising
// edge with valid high and stall low. Every sample yields one result.
// Pipeline: input gain, alpha product, 30 CORDIC rotations (one register
// each), magnitude scaling, blend products, blend sum, and output gain in
// the output register: 36 register stages, whatever SAMPLE_BITS is.
// Throughput is one sample per cycle while the receiver does not stall;
// the CORDIC rotation chain sets depth.
// The whole pipeline advances together whenever the output register is
// empty or being taken; when the receiver stalls with a full output, every
// stage holds and in_stall rises, so nothing is lost or repeated.
// Configuration: cfg_we/cfg_index/cfg_data write register cfg_index (0..3);
// write only when the pipeline is empty. Reset (synchronous) empties the
// pipeline and loads unity gains, alpha 1.5 and fully wet blend.
`timescale 1ns / 1ps
module arctan_soft_clip_drive #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [ascd_pkg::GainBits-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample
);
  import ascd_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int XW  = SB + 26;        // CORDIC datapath width
  localparam int PW  = SB + 1;         // carried dry sample and sign
  localparam int NST = CordicSteps;
  localparam logic signed [SB+1:0] SMAX = (SB+2)'((64'sd1 <<< (SB-1)) - 1);
  localparam logic signed [SB+1:0] SMIN = (SB+2)'(-(64'sd1 <<< (SB-1)));

  // saturate a wide value to SB signed bits
  function automatic logic signed [SB-1:0] sat_w(input logic signed [SB+30:0] v);
    logic signed [SB-1:0] r;
    if (v > (SB+31)'(SMAX)) r = SMAX[SB-1:0];
    else if (v < (SB+31)'(SMIN)) r = SMIN[SB-1:0];
    else r = v[SB-1:0];
    return r;
  endfunction

  // configuration registers
  logic [GainBits-1:0]  input_gain, output_gain, clip_alpha;
  logic [ShareBits-1:0] wet_share;
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain  <= GainBits'(4096);
      output_gain <= GainBits'(4096);
      clip_alpha  <= GainBits'(AlphaMin);
      wet_share   <= ShareBits'(ShareOne);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_INPUT_GAIN:  input_gain  <= cfg_data;
        REG_OUTPUT_GAIN: output_gain <= cfg_data;
        REG_CLIP_ALPHA:  clip_alpha  <= cfg_data;
        REG_WET_SHARE:   wet_share   <= cfg_data[ShareBits-1:0];
        default: ;
      endcase
    end
  end

  logic [GainBits-1:0] alpha_c;
  logic [12:0]         share_c;
  always_comb begin
    if (clip_alpha < GainBits'(AlphaMin)) alpha_c = GainBits'(AlphaMin);
    else if (clip_alpha > GainBits'(AlphaMax)) alpha_c = GainBits'(AlphaMax);
    else alpha_c = clip_alpha;
    share_c = (wet_share > ShareBits'(ShareOne)) ? 13'(ShareOne) : wet_share;
  end

  // global advance: output free or being taken
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage A: input gain
  logic                 a_vld;
  logic signed [SB-1:0] a_d;
  logic signed [SB+30:0] a_prod;
  assign a_prod = ((SB+31)'(in_sample) * $signed({1'b0, input_gain})
                   + (SB+31)'(2048)) >>> GainFrac;
  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) a_d <= sat_w(a_prod);
  end

  // stage B: drive product, |t| and sign
  logic                 b_vld, b_neg, b_zero;
  logic signed [SB-1:0] b_d;
  logic signed [XW-1:0] b_t;
  logic signed [XW-1:0] t_full;
  assign t_full = XW'(a_d) * $signed({1'b0, alpha_c});
  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_d    <= a_d;
      b_neg  <= t_full[XW-1];
      b_zero <= (t_full == '0);
      b_t    <= t_full[XW-1] ? -t_full : t_full;
    end
  end

  // CORDIC chain: one registered rotation per step
  logic                 c_vld [NST+1];
  logic signed [XW-1:0] c_x   [NST+1];
  logic signed [XW-1:0] c_y   [NST+1];
  logic signed [33:0]   c_z   [NST+1];
  logic [PW-1:0]        c_p   [NST+1];
  logic                 b_sgn;
  assign b_sgn    = b_neg;
  assign c_vld[0] = b_vld;
  assign c_x[0]   = XW'(64'sd1 <<< (SB + 11));
  assign c_y[0]   = b_t;
  assign c_z[0]   = b_zero ? 34'sh2_0000_0000 : '0;  // marker bit 33 set: zero t
  assign c_p[0]   = {b_sgn, b_d};

  for (genvar i = 0; i < NST; i++) begin : g_cordic
    ascd_cordic_stage #(.XW(XW), .PW(PW), .STEP(i)) u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .in_vld  (c_vld[i]),
      .x_in    (c_x[i]),
      .y_in    (c_y[i]),
      .z_in    (c_z[i]),
      .pay_in  (c_p[i]),
      .out_vld (c_vld[i+1]),
      .x_out   (c_x[i+1]),
      .y_out   (c_y[i+1]),
      .z_out   (c_z[i+1]),
      .pay_out (c_p[i+1])
    );
  end

  // The zero marker sits far above any angle sum (|z| < 2^31), so it survives.
  logic                 e_zero;
  logic signed [33:0]   e_zs;
  assign e_zero = c_z[NST][33] ^ c_z[NST][32];  // marker flips top two bits
  assign e_zs   = e_zero ? c_z[NST] - 34'sh2_0000_0000 : c_z[NST];

  // stage M: wet magnitude
  logic                 m_vld;
  logic signed [SB-1:0] m_d, m_w;
  logic [31:0]          zpos;
  logic [SB+31:0]       mag_w;
  logic [SB-1:0]        mag;
  always_comb begin
    zpos  = e_zs[33] ? '0 : e_zs[31:0];
    mag_w = ((SB+32)'(zpos) << (SB-1)) + (SB+32)'(64'd1 << 29);
    mag_w = mag_w >> 30;
    if (mag_w > (SB+32)'((64'd1 << (SB-1)) - 1)) mag = SB'((64'd1 << (SB-1)) - 1);
    else mag = mag_w[SB-1:0];
  end
  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else if (adv) m_vld <= c_vld[NST];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_d <= c_p[NST][SB-1:0];
      if (e_zero) m_w <= '0;
      else m_w <= c_p[NST][SB] ? -$signed(mag) : $signed(mag);
    end
  end

  // stage P: blend products
  logic                  p_vld;
  logic signed [SB+14:0] p_dry, p_wet;
  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else if (adv) p_vld <= m_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p_dry <= (SB+15)'(m_d) * $signed({1'b0, 13'(ShareOne) - share_c});
      p_wet <= (SB+15)'(m_w) * $signed({1'b0, share_c});
    end
  end

  // stage S: blend sum, rounding, saturation
  logic                  s_vld;
  logic signed [SB-1:0]  s_m;
  logic signed [SB+30:0] s_sum;
  assign s_sum = ((SB+31)'(p_dry) + (SB+31)'(p_wet) + (SB+31)'(2048)) >>> GainFrac;
  always_ff @(posedge clk) begin
    if (rst) s_vld <= 1'b0;
    else if (adv) s_vld <= p_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) s_m <= sat_w(s_sum);
  end

  // output register: output gain
  logic signed [SB+30:0] o_prod;
  assign o_prod = ((SB+31)'(s_m) * $signed({1'b0, output_gain})
                   + (SB+31)'(2048)) >>> GainFrac;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) out_sample <= sat_w(o_prod);
  end

  // checks
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_sample))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_vld && adv && (m_d == '0) |=> p_wet == '0)
    else $error("zero dry sample gave nonzero wet signal");

endmodule
